// ===== rtl/apcs_pkg.sv =====
// apcs_pkg: shared constants, register codes and control structs for the
// absolute pointer calibrate/smooth block. No dependencies.
package apcs_pkg;

  // sample and position widths
  localparam int SAMPLE_BITS = 12;
  localparam int POS_W       = 15;
  localparam int SMOOTH_W    = 7;
  // dividend width covers (v - low) * 32767
  localparam int NUM_W       = SAMPLE_BITS + POS_W;
  // blend sum width: prev*f + fresh*(100-f) <= 32767*100
  localparam int ACC_W       = 22;
  localparam int DEAD_W      = 9;

  localparam logic [POS_W-1:0]       CENTER_POS = 15'd16384;
  localparam logic [SAMPLE_BITS-1:0] MIN_SPAN   = 12'd10;
  localparam logic [SMOOTH_W-1:0]    MAX_SMOOTH = 7'd95;
  localparam logic [DEAD_W-1:0]      DEAD_BASE  = 9'd20;
  localparam logic [SMOOTH_W-1:0]    PERCENT    = 7'd100;

  // reset values of the calibration registers
  localparam logic [SAMPLE_BITS-1:0] RST_LOW_CAL  = 12'd200;
  localparam logic [SAMPLE_BITS-1:0] RST_HIGH_CAL = 12'd3900;
  localparam logic [SMOOTH_W-1:0]    RST_SMOOTH   = 7'd60;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_SMOOTH = 3'd4
  } cfg_reg_e;

  // button bit positions in the report
  localparam int BTN_PRIMARY   = 0;
  localparam int BTN_SECONDARY = 1;

  // request to the serial divider
  typedef struct packed {
    logic                   start;
    logic [NUM_W-1:0]       dividend;
    logic [SAMPLE_BITS-1:0] divisor;
  } div_req_t;

  // divider answer
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
  } div_rsp_t;

  // command to one axis lane
  typedef struct packed {
    logic                   start;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SMOOTH_W-1:0]    smooth;
  } axis_cmd_t;

  // answer of one axis lane
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
  } axis_rsp_t;

endpackage

// ===== rtl/apcs_if.sv =====
// apcs_if: valid/ready channel interfaces for sample input, report output
// and register writes. Depends on apcs_pkg.
interface apcs_in_if;
  logic                            valid;
  logic                            ready;
  logic [apcs_pkg::SAMPLE_BITS-1:0] raw_x;
  logic [apcs_pkg::SAMPLE_BITS-1:0] raw_y;
  logic                            enable_in;
  logic                            trigger_in;
  logic                            secondary_in;

  modport source (output valid, raw_x, raw_y, enable_in, trigger_in, secondary_in,
                  input ready);
  modport sink   (input valid, raw_x, raw_y, enable_in, trigger_in, secondary_in,
                  output ready);
endinterface

interface apcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [apcs_pkg::POS_W-1:0] pos_x;
  logic [apcs_pkg::POS_W-1:0] pos_y;
  logic [1:0]                button_bits;

  modport source (output valid, pos_x, pos_y, button_bits, input ready);
  modport sink   (input valid, pos_x, pos_y, button_bits, output ready);
endinterface

interface apcs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [apcs_pkg::CFG_IDX_W-1:0]   index;
  logic [apcs_pkg::SAMPLE_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/absolute_pointer_calibrate_smooth.sv =====
// Calibrated absolute pointer: takes one X/Y sample word with button levels
// and returns one report word with filtered 15-bit positions and buttons.
// The two axes run side by side in their own lanes and the slower lane sets
// the time. When an axis has to blend, its word passes in order through the
// start of the scaling divider, the quotient bits, the take of the quotient,
// the deadband test, 7 bit-serial multiply steps, the same divider sequence
// for the divide by 100, and the hand-off into the output register; the
// input opens in the same cycle as the report turns valid. An axis inside
// its deadband skips the multiply and the divide by 100, and a degenerate
// calibration skips the scaling division.
// One item is processed at a time; the next word is taken while a finished
// report waits in the output register, and a stalled output holds back only
// the following report. Register writes are taken at any time but must
// only be issued while the block is idle.
// Depends on apcs_pkg, apcs_if and apcs_axis.
module absolute_pointer_calibrate_smooth (
  input  logic       clk,
  input  logic       rst,
  apcs_in_if.sink    sample_ch,
  apcs_out_if.source report_ch,
  apcs_cfg_if.sink   cfg
);

  logic [apcs_pkg::SAMPLE_BITS-1:0] x_low_cal;
  logic [apcs_pkg::SAMPLE_BITS-1:0] x_high_cal;
  logic [apcs_pkg::SAMPLE_BITS-1:0] y_low_cal;
  logic [apcs_pkg::SAMPLE_BITS-1:0] y_high_cal;
  logic [apcs_pkg::SMOOTH_W-1:0]    smoothing;

  logic                             busy;
  logic                             x_seen;
  logic                             y_seen;
  logic [1:0]                       btn;
  logic                             out_valid;
  logic [apcs_pkg::POS_W-1:0]       out_x;
  logic [apcs_pkg::POS_W-1:0]       out_y;
  logic [1:0]                       out_btn;
  logic                             in_acc;
  logic                             load;

  apcs_pkg::axis_cmd_t              x_cmd;
  apcs_pkg::axis_cmd_t              y_cmd;
  apcs_pkg::axis_rsp_t              x_rsp;
  apcs_pkg::axis_rsp_t              y_rsp;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_cal  <= apcs_pkg::RST_LOW_CAL;
      x_high_cal <= apcs_pkg::RST_HIGH_CAL;
      y_low_cal  <= apcs_pkg::RST_LOW_CAL;
      y_high_cal <= apcs_pkg::RST_HIGH_CAL;
      smoothing  <= apcs_pkg::RST_SMOOTH;
    end else if (cfg.valid) begin
      unique case (apcs_pkg::cfg_reg_e'(cfg.index))
        apcs_pkg::REG_X_LOW:  x_low_cal  <= cfg.data;
        apcs_pkg::REG_X_HIGH: x_high_cal <= cfg.data;
        apcs_pkg::REG_Y_LOW:  y_low_cal  <= cfg.data;
        apcs_pkg::REG_Y_HIGH: y_high_cal <= cfg.data;
        apcs_pkg::REG_SMOOTH: smoothing  <= cfg.data[apcs_pkg::SMOOTH_W-1:0];
        default: ;
      endcase
    end
  end

  // input word starts both lanes
  assign sample_ch.ready = !busy;
  assign in_acc          = sample_ch.valid && !busy;

  always_comb begin
    x_cmd.start  = in_acc;
    x_cmd.sample = sample_ch.raw_x;
    x_cmd.lo     = x_low_cal;
    x_cmd.hi     = x_high_cal;
    x_cmd.smooth = smoothing;
    y_cmd.start  = in_acc;
    y_cmd.sample = sample_ch.raw_y;
    y_cmd.lo     = y_low_cal;
    y_cmd.hi     = y_high_cal;
    y_cmd.smooth = smoothing;
  end

  apcs_axis u_axis_x (
    .clk (clk),
    .rst (rst),
    .cmd (x_cmd),
    .rsp (x_rsp)
  );

  apcs_axis u_axis_y (
    .clk (clk),
    .rst (rst),
    .cmd (y_cmd),
    .rsp (y_rsp)
  );

  // report leaves when both lanes are through and the output register is free
  assign load = busy && x_seen && y_seen && (!out_valid || report_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      x_seen    <= 1'b0;
      y_seen    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
        btn  <= sample_ch.enable_in ? {sample_ch.secondary_in, sample_ch.trigger_in}
                                    : 2'b00;
      end
      if (x_rsp.done) begin
        x_seen <= 1'b1;
      end
      if (y_rsp.done) begin
        y_seen <= 1'b1;
      end
      if (load) begin
        busy      <= 1'b0;
        x_seen    <= 1'b0;
        y_seen    <= 1'b0;
        out_valid <= 1'b1;
        out_x     <= x_rsp.pos;
        out_y     <= y_rsp.pos;
        out_btn   <= btn;
      end else if (report_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign report_ch.valid       = out_valid;
  assign report_ch.pos_x       = out_x;
  assign report_ch.pos_y       = out_y;
  assign report_ch.button_bits = out_btn;

endmodule

// ===== rtl/apcs_div.sv =====
// apcs_div: restoring divider, one quotient bit per cycle, 15-bit quotient.
// Depends on apcs_pkg. Caller guarantees dividend < divisor * 2^15.
module apcs_div (
  input  logic               clk,
  input  logic               rst,
  input  apcs_pkg::div_req_t req,
  output apcs_pkg::div_rsp_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                        state;
  logic [apcs_pkg::NUM_W-1:0]    rem;
  logic [apcs_pkg::NUM_W-1:0]    dsh;
  logic [apcs_pkg::POS_W-1:0]    quot;
  logic [3:0]                    cnt;
  logic                          done;
  logic                          fits;

  // trial subtract of the shifted divisor
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            rem   <= req.dividend;
            dsh   <= {1'b0, req.divisor, {(apcs_pkg::POS_W-1){1'b0}}};
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (fits) begin
            rem <= rem - dsh;
          end
          quot <= {quot[apcs_pkg::POS_W-2:0], fits};
          dsh  <= dsh >> 1;
          cnt  <= cnt + 4'd1;
          if (cnt == 4'(apcs_pkg::POS_W-1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== rtl/apcs_axis.sv =====
// apcs_axis: one axis lane: clamp, scale through the serial divider,
// deadband test, bit-serial blend multiply and divide by 100.
// Depends on apcs_pkg and apcs_div.
module apcs_axis (
  input  logic                clk,
  input  logic                rst,
  input  apcs_pkg::axis_cmd_t cmd,
  output apcs_pkg::axis_rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_CHECK,
    S_MUL,
    S_BLEND
  } state_t;

  state_t                             state;
  logic [apcs_pkg::POS_W-1:0]         prev;
  logic [apcs_pkg::POS_W-1:0]         fresh;
  logic [apcs_pkg::ACC_W-1:0]         acc;
  logic [apcs_pkg::ACC_W-1:0]         pa;
  logic [apcs_pkg::ACC_W-1:0]         fa;
  logic [apcs_pkg::SMOOTH_W-1:0]      fm;
  logic [apcs_pkg::SMOOTH_W-1:0]      gm;
  logic [2:0]                         cnt;
  logic                               done;
  apcs_pkg::div_req_t                 div_req;
  apcs_pkg::div_rsp_t                 div_rsp;

  logic [apcs_pkg::SAMPLE_BITS-1:0]   v_c;
  logic [apcs_pkg::SAMPLE_BITS-1:0]   d;
  logic [apcs_pkg::SAMPLE_BITS-1:0]   span;
  logic [apcs_pkg::NUM_W-1:0]         num;
  logic                               degen;
  logic [apcs_pkg::SMOOTH_W-1:0]      f_c;
  logic [apcs_pkg::DEAD_W-1:0]        dead;
  logic [apcs_pkg::POS_W-1:0]         delta;
  logic [apcs_pkg::ACC_W-1:0]         acc_next;

  apcs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // clamp to calibration and form (v - low) * 32767
  always_comb begin
    if (cmd.sample < cmd.lo) begin
      v_c = cmd.lo;
    end else if (cmd.sample > cmd.hi) begin
      v_c = cmd.hi;
    end else begin
      v_c = cmd.sample;
    end
    d     = v_c - cmd.lo;
    span  = cmd.hi - cmd.lo;
    num   = {d, {apcs_pkg::POS_W{1'b0}}} - {{apcs_pkg::POS_W{1'b0}}, d};
    degen = ({1'b0, cmd.hi} <= ({1'b0, cmd.lo} + {1'b0, apcs_pkg::MIN_SPAN}));
  end

  // filter strength, deadband width and distance to last position
  always_comb begin
    f_c   = (cmd.smooth > apcs_pkg::MAX_SMOOTH) ? apcs_pkg::MAX_SMOOTH : cmd.smooth;
    dead  = apcs_pkg::DEAD_BASE + {f_c, 2'b00};
    delta = (fresh > prev) ? (fresh - prev) : (prev - fresh);
  end

  // one shift-add step of prev*f + fresh*(100-f)
  assign acc_next = acc + (fm[0] ? pa : '0) + (gm[0] ? fa : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev          <= apcs_pkg::CENTER_POS;
      done          <= 1'b0;
      div_req.start <= 1'b0;
      cnt           <= '0;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            if (degen) begin
              fresh <= apcs_pkg::CENTER_POS;
              state <= S_CHECK;
            end else begin
              div_req.start    <= 1'b1;
              div_req.dividend <= num;
              div_req.divisor  <= span;
              state            <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (div_rsp.done) begin
            fresh <= div_rsp.quot;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (delta < {{(apcs_pkg::POS_W-apcs_pkg::DEAD_W){1'b0}}, dead}) begin
            // inside the deadband: keep the last position
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            acc   <= '0;
            pa    <= {{(apcs_pkg::ACC_W-apcs_pkg::POS_W){1'b0}}, prev};
            fa    <= {{(apcs_pkg::ACC_W-apcs_pkg::POS_W){1'b0}}, fresh};
            fm    <= f_c;
            gm    <= apcs_pkg::PERCENT - f_c;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= acc_next;
          pa  <= pa << 1;
          fa  <= fa << 1;
          fm  <= fm >> 1;
          gm  <= gm >> 1;
          cnt <= cnt + 3'd1;
          if (cnt == 3'(apcs_pkg::SMOOTH_W-1)) begin
            div_req.start    <= 1'b1;
            div_req.dividend <= {{(apcs_pkg::NUM_W-apcs_pkg::ACC_W){1'b0}}, acc_next};
            div_req.divisor  <= {{(apcs_pkg::SAMPLE_BITS-apcs_pkg::SMOOTH_W){1'b0}},
                                 apcs_pkg::PERCENT};
            state            <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (div_rsp.done) begin
            prev  <= div_rsp.quot;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.pos  = prev;

endmodule

// ===== rtl/apcs_checker.sv =====
// apcs_checker: port-level checks on the pointer block, attached by bind.
// Depends only on the top level's channel signals.
module apcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] pos_x,
  input logic [14:0] pos_y,
  input logic [1:0]  button_bits
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // stalled report stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("report dropped while stalled");

  // stalled report keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(button_bits))
    else $error("report changed while stalled");

  // one word in flight: input closes right after a take
  a_in_close: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second word taken while busy");

  // every report belongs to a taken word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("report without a word");

  // at most one in process and one waiting
  a_bound: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> pending <= 2'd1)
    else $error("too many words outstanding");

endmodule

bind absolute_pointer_calibrate_smooth apcs_checker u_apcs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_ch.valid),
  .in_ready    (sample_ch.ready),
  .out_valid   (report_ch.valid),
  .out_ready   (report_ch.ready),
  .pos_x       (report_ch.pos_x),
  .pos_y       (report_ch.pos_y),
  .button_bits (report_ch.button_bits)
);
